// ===== rtl/core/assert_macros.svh =====
// Assertion helpers included by plc_ctrl.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PLC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define PLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PLC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define PLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/plc_pkg.sv =====
package plc_pkg;

    localparam int SUM_W       = 24;
    localparam int ACC_W       = 63;
    localparam int CELLS_MAX_DEF = 64;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [15:0] WEIGHT_RESET = 16'd256;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_AGG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LOC = 1'd1;

    // Operand selection of the shared multiplier.
    localparam int MUL_SEL_W = 3;
    localparam logic [MUL_SEL_W-1:0] MS_VEG = 3'd0;
    localparam logic [MUL_SEL_W-1:0] MS_BLT = 3'd1;
    localparam logic [MUL_SEL_W-1:0] MS_WAT = 3'd2;
    localparam logic [MUL_SEL_W-1:0] MS_LOC = 3'd3;
    localparam logic [MUL_SEL_W-1:0] MS_AGG = 3'd4;
    localparam logic [MUL_SEL_W-1:0] MS_REC = 3'd5;
    localparam logic [MUL_SEL_W-1:0] MS_WGT = 3'd6;

    typedef struct packed {
        logic signed [15:0] fine_temperature;
        logic signed [15:0] vegetation_index;
        logic signed [15:0] built_index;
        logic signed [15:0] water_index;
        logic signed [15:0] coarse_offset;
        logic signed [15:0] reference_temperature;
        logic signed [15:0] coef_vegetation;
        logic signed [15:0] coef_built;
        logic signed [15:0] coef_water;
        logic signed [15:0] model_intercept;
        logic               hex_end;
        logic               batch_end;
    } plc_in_t;

    typedef struct packed {
        logic [ACC_W-1:0] loss_reconstruction;
        logic [ACC_W-1:0] loss_aggregate;
        logic [ACC_W-1:0] loss_local;
        logic [ACC_W-1:0] loss_total;
        logic             overflow_flag;
    } plc_out_t;

    typedef struct packed {
        logic                 load_item;
        logic [MUL_SEL_W-1:0] mul_sel;
        logic                 cell_upd;
        logic                 res_sub;
        logic                 loc_add;
        logic                 agg_add;
        logic                 rec_add;
        logic                 div_start;
        logic                 div_sel;
        logic                 hex_clr;
        logic                 tot_init;
        logic                 w_sel;
        logic [1:0]           chunk;
        logic                 w_clr;
        logic                 w_acc;
        logic                 tot_add;
        logic                 out_ld;
    } plc_cmd_t;

    typedef struct packed {
        logic close;
        logic batch;
        logic div_done;
        logic out_free;
    } plc_status_t;

endpackage

// ===== rtl/core/plc_div.sv =====
module plc_div #(
    parameter int DW = 7
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [plc_pkg::SUM_W-1:0]  dividend,
    input  logic [DW-1:0]                     divisor,
    output logic                              done,
    output logic signed [plc_pkg::SUM_W-1:0]  quotient
);

    localparam int SW = plc_pkg::SUM_W;
    localparam int STEP_W = $clog2(SW);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DW:0]       rem_reg;
    logic [SW-1:0]     quo_reg;
    logic [DW:0]       rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg[DW-1:0], quo_reg[SW-1]};
    assign fits   = rem_sh >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == STEP_W'(SW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg  <= dividend[SW-1];
            quo_reg  <= dividend[SW-1] ? SW'(-dividend) : dividend;
            rem_reg  <= '0;
            step_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? rem_sh - {1'b0, divisor} : rem_sh;
            quo_reg  <= {quo_reg[SW-2:0], fits};
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ===== rtl/core/plc_dp.sv =====
module plc_dp #(
    parameter int CELLS_MAX = plc_pkg::CELLS_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  plc_pkg::plc_cmd_t                 cmd,
    output plc_pkg::plc_status_t              status,
    input  plc_pkg::plc_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output plc_pkg::plc_out_t                 m_data,
    input  logic                              cfg_wr_en,
    input  logic [plc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [plc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(CELLS_MAX + 1);
    localparam int SW    = plc_pkg::SUM_W;
    localparam int AW    = plc_pkg::ACC_W;

    function automatic logic [AW:0] sat_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[AW] ? {1'b1, plc_pkg::ACC_MAX} : s;
    endfunction

    function automatic logic [SW:0] sat_add24(input logic signed [SW-1:0] a,
                                              input logic signed [16:0] b);
        logic signed [SW:0] s;
        s = {a[SW-1], a} + {{(SW-16){b[16]}}, b};
        if (s[SW] != s[SW-1]) begin
            sat_add24 = {1'b1, s[SW], {(SW-1){~s[SW]}}};
        end else begin
            sat_add24 = {1'b0, s[SW-1:0]};
        end
    endfunction

    plc_pkg::plc_in_t    item_reg;
    logic [15:0]         weight_agg_reg;
    logic [15:0]         weight_loc_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic signed [SW-1:0] dev_sum_reg;
    logic signed [SW-1:0] temp_sum_reg;
    logic                flag_reg;
    logic                flag_next;
    logic [AW-1:0]       acc_loc_reg;
    logic [AW-1:0]       acc_agg_reg;
    logic [AW-1:0]       acc_rec_reg;
    logic signed [34:0]  res_reg;
    logic signed [51:0]  prod_reg;
    logic signed [51:0]  prod_next;
    logic signed [SW-1:0] mean_dev_reg;
    logic signed [SW-1:0] mean_t_reg;
    logic [78:0]         wsum_reg;
    logic [AW-1:0]       total_reg;
    logic [AW-1:0]       total_next;
    plc_pkg::plc_out_t   out_reg;
    logic                m_valid_reg;

    logic signed [16:0]  dev;
    logic signed [17:0]  dev_cd;
    logic signed [34:0]  res_rnd;
    logic signed [20:0]  res8;
    logic signed [24:0]  agg_res;
    logic signed [25:0]  rec_res;
    logic signed [25:0]  mul_a;
    logic signed [25:0]  mul_b;
    logic [63:0]         chunk_src;
    logic [15:0]         chunk;
    logic [15:0]         wgt;
    logic                has_room;
    logic [SW:0]         dev_upd;
    logic [SW:0]         temp_upd;
    logic [AW:0]         loc_upd;
    logic [AW:0]         agg_upd;
    logic [AW:0]         rec_upd;
    logic [AW:0]         tot_upd;
    logic                wsum_ovf;
    logic                div_done;
    logic signed [SW-1:0] quotient;

    assign dev = {item_reg.fine_temperature[15], item_reg.fine_temperature}
               - {item_reg.reference_temperature[15], item_reg.reference_temperature};
    assign dev_cd = {dev[16], dev} - {{2{item_reg.model_intercept[15]}}, item_reg.model_intercept};

    // Round the Q.22 residual to Q.8, half toward plus infinity.
    assign res_rnd = res_reg + 35'sd8192;
    assign res8    = res_rnd[34:14];

    assign agg_res = {mean_dev_reg[SW-1], mean_dev_reg}
                   - {{9{item_reg.coarse_offset[15]}}, item_reg.coarse_offset};
    assign rec_res = {{2{mean_t_reg[SW-1]}}, mean_t_reg}
                   - ({{10{item_reg.coarse_offset[15]}}, item_reg.coarse_offset}
                    + {{10{item_reg.reference_temperature[15]}}, item_reg.reference_temperature});

    assign chunk_src = cmd.w_sel ? {1'b0, acc_loc_reg} : {1'b0, acc_agg_reg};
    assign chunk     = chunk_src[cmd.chunk*16 +: 16];
    assign wgt       = cmd.w_sel ? weight_loc_reg : weight_agg_reg;

    always_comb begin
        case (cmd.mul_sel)
            plc_pkg::MS_VEG: begin
                mul_a = {{10{item_reg.coef_vegetation[15]}}, item_reg.coef_vegetation};
                mul_b = {{10{item_reg.vegetation_index[15]}}, item_reg.vegetation_index};
            end
            plc_pkg::MS_BLT: begin
                mul_a = {{10{item_reg.coef_built[15]}}, item_reg.coef_built};
                mul_b = {{10{item_reg.built_index[15]}}, item_reg.built_index};
            end
            plc_pkg::MS_WAT: begin
                mul_a = {{10{item_reg.coef_water[15]}}, item_reg.coef_water};
                mul_b = {{10{item_reg.water_index[15]}}, item_reg.water_index};
            end
            plc_pkg::MS_LOC: begin
                mul_a = {{5{res8[20]}}, res8};
                mul_b = {{5{res8[20]}}, res8};
            end
            plc_pkg::MS_AGG: begin
                mul_a = {agg_res[24], agg_res};
                mul_b = {agg_res[24], agg_res};
            end
            plc_pkg::MS_REC: begin
                mul_a = rec_res;
                mul_b = rec_res;
            end
            plc_pkg::MS_WGT: begin
                mul_a = {10'd0, chunk};
                mul_b = {10'd0, wgt};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    assign has_room = cnt_reg < CNT_W'(CELLS_MAX);
    assign dev_upd  = sat_add24(dev_sum_reg, dev);
    assign temp_upd = sat_add24(temp_sum_reg,
                                {item_reg.fine_temperature[15], item_reg.fine_temperature});
    assign loc_upd  = sat_add(acc_loc_reg, {12'd0, prod_reg[50:0]});
    assign agg_upd  = sat_add(acc_agg_reg, {12'd0, prod_reg[50:0]});
    assign rec_upd  = sat_add(acc_rec_reg, {12'd0, prod_reg[50:0]});
    assign wsum_ovf = |wsum_reg[78:71];
    assign tot_upd  = sat_add(total_reg, wsum_reg[70:8]);
    assign total_next = wsum_ovf ? plc_pkg::ACC_MAX : tot_upd[AW-1:0];

    always_comb begin
        flag_next = flag_reg;
        if (cmd.cell_upd) begin
            flag_next = flag_next | ~has_room | dev_upd[SW] | temp_upd[SW];
        end
        if (cmd.loc_add) begin
            flag_next = flag_next | loc_upd[AW];
        end
        if (cmd.agg_add) begin
            flag_next = flag_next | agg_upd[AW];
        end
        if (cmd.rec_add) begin
            flag_next = flag_next | rec_upd[AW];
        end
        if (cmd.tot_add) begin
            flag_next = flag_next | wsum_ovf | tot_upd[AW];
        end
        if (cmd.out_ld) begin
            flag_next = 1'b0;
        end
    end

    plc_div #(
        .DW(CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (cmd.div_sel ? temp_sum_reg : dev_sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_agg_reg <= plc_pkg::WEIGHT_RESET;
            weight_loc_reg <= plc_pkg::WEIGHT_RESET;
            cnt_reg        <= '0;
            dev_sum_reg    <= '0;
            temp_sum_reg   <= '0;
            flag_reg       <= 1'b0;
            acc_loc_reg    <= '0;
            acc_agg_reg    <= '0;
            acc_rec_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_index == plc_pkg::CFG_WEIGHT_AGG) begin
                weight_agg_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index == plc_pkg::CFG_WEIGHT_LOC) begin
                weight_loc_reg <= cfg_data;
            end
            flag_reg <= flag_next;
            if (cmd.hex_clr) begin
                cnt_reg      <= '0;
                dev_sum_reg  <= '0;
                temp_sum_reg <= '0;
            end else if (cmd.cell_upd && has_room) begin
                cnt_reg      <= cnt_reg + CNT_W'(1);
                dev_sum_reg  <= dev_upd[SW-1:0];
                temp_sum_reg <= temp_upd[SW-1:0];
            end
            if (cmd.out_ld) begin
                acc_loc_reg <= '0;
                acc_agg_reg <= '0;
                acc_rec_reg <= '0;
            end else begin
                if (cmd.loc_add) begin
                    acc_loc_reg <= loc_upd[AW-1:0];
                end
                if (cmd.agg_add) begin
                    acc_agg_reg <= agg_upd[AW-1:0];
                end
                if (cmd.rec_add) begin
                    acc_rec_reg <= rec_upd[AW-1:0];
                end
            end
            if (cmd.out_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        prod_reg <= prod_next;
        if (cmd.cell_upd) begin
            res_reg <= {{3{dev_cd[17]}}, dev_cd, 14'd0};
        end else if (cmd.res_sub) begin
            res_reg <= res_reg - prod_reg[34:0];
        end
        if (div_done) begin
            if (cmd.div_sel) begin
                mean_t_reg <= quotient;
            end else begin
                mean_dev_reg <= quotient;
            end
        end
        if (cmd.w_clr) begin
            wsum_reg <= '0;
        end else if (cmd.w_acc) begin
            wsum_reg <= {wsum_reg[62:0], 16'd0} + {47'd0, prod_reg[31:0]};
        end
        if (cmd.tot_init) begin
            total_reg <= acc_rec_reg;
        end else if (cmd.tot_add) begin
            total_reg <= total_next;
        end
        if (cmd.out_ld) begin
            out_reg.loss_reconstruction <= acc_rec_reg;
            out_reg.loss_aggregate      <= acc_agg_reg;
            out_reg.loss_local          <= acc_loc_reg;
            out_reg.loss_total          <= total_reg;
            out_reg.overflow_flag       <= flag_reg;
        end
    end

    assign status.close    = item_reg.hex_end | item_reg.batch_end;
    assign status.batch    = item_reg.batch_end;
    assign status.div_done = div_done;
    assign status.out_free = ~m_valid_reg | m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/core/plc_ctrl.sv =====
`include "assert_macros.svh"

module plc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  plc_pkg::plc_status_t  status,
    output plc_pkg::plc_cmd_t     cmd
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_MUL_V  = 5'd1;
    localparam logic [4:0] ST_MUL_B  = 5'd2;
    localparam logic [4:0] ST_MUL_W  = 5'd3;
    localparam logic [4:0] ST_RES    = 5'd4;
    localparam logic [4:0] ST_SQ_L   = 5'd5;
    localparam logic [4:0] ST_ADD_L  = 5'd6;
    localparam logic [4:0] ST_DIV_D  = 5'd7;
    localparam logic [4:0] ST_WAIT_D = 5'd8;
    localparam logic [4:0] ST_DIV_T  = 5'd9;
    localparam logic [4:0] ST_WAIT_T = 5'd10;
    localparam logic [4:0] ST_SQ_A   = 5'd11;
    localparam logic [4:0] ST_ADD_A  = 5'd12;
    localparam logic [4:0] ST_SQ_R   = 5'd13;
    localparam logic [4:0] ST_ADD_R  = 5'd14;
    localparam logic [4:0] ST_TOT    = 5'd15;
    localparam logic [4:0] ST_W_MUL  = 5'd16;
    localparam logic [4:0] ST_W_ACC  = 5'd17;
    localparam logic [4:0] ST_W_ADD  = 5'd18;
    localparam logic [4:0] ST_OUT    = 5'd19;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [1:0] chunk_reg;
    logic [1:0] chunk_next;
    logic       wsel_reg;
    logic       wsel_next;

    always_comb begin
        state_next = state_reg;
        chunk_next = chunk_reg;
        wsel_next  = wsel_reg;
        cmd        = '0;
        cmd.chunk  = chunk_reg;
        cmd.w_sel  = wsel_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_MUL_V;
                end
            end
            ST_MUL_V: begin
                cmd.mul_sel  = plc_pkg::MS_VEG;
                cmd.cell_upd = 1'b1;
                state_next   = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.mul_sel = plc_pkg::MS_BLT;
                cmd.res_sub = 1'b1;
                state_next  = ST_MUL_W;
            end
            ST_MUL_W: begin
                cmd.mul_sel = plc_pkg::MS_WAT;
                cmd.res_sub = 1'b1;
                state_next  = ST_RES;
            end
            ST_RES: begin
                cmd.res_sub = 1'b1;
                state_next  = ST_SQ_L;
            end
            ST_SQ_L: begin
                cmd.mul_sel = plc_pkg::MS_LOC;
                state_next  = ST_ADD_L;
            end
            ST_ADD_L: begin
                cmd.loc_add = 1'b1;
                state_next  = status.close ? ST_DIV_D : ST_IDLE;
            end
            ST_DIV_D: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_D;
            end
            ST_WAIT_D: begin
                if (status.div_done) begin
                    state_next = ST_DIV_T;
                end
            end
            ST_DIV_T: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_WAIT_T;
            end
            ST_WAIT_T: begin
                cmd.div_sel = 1'b1;
                if (status.div_done) begin
                    state_next = ST_SQ_A;
                end
            end
            ST_SQ_A: begin
                cmd.mul_sel = plc_pkg::MS_AGG;
                state_next  = ST_ADD_A;
            end
            ST_ADD_A: begin
                cmd.agg_add = 1'b1;
                state_next  = ST_SQ_R;
            end
            ST_SQ_R: begin
                cmd.mul_sel = plc_pkg::MS_REC;
                state_next  = ST_ADD_R;
            end
            ST_ADD_R: begin
                cmd.rec_add = 1'b1;
                cmd.hex_clr = 1'b1;
                state_next  = status.batch ? ST_TOT : ST_IDLE;
            end
            ST_TOT: begin
                cmd.tot_init = 1'b1;
                cmd.w_clr    = 1'b1;
                chunk_next   = 2'd3;
                wsel_next    = 1'b0;
                state_next   = ST_W_MUL;
            end
            ST_W_MUL: begin
                cmd.mul_sel = plc_pkg::MS_WGT;
                state_next  = ST_W_ACC;
            end
            ST_W_ACC: begin
                cmd.w_acc = 1'b1;
                if (chunk_reg == 2'd0) begin
                    state_next = ST_W_ADD;
                end else begin
                    chunk_next = chunk_reg - 2'd1;
                    state_next = ST_W_MUL;
                end
            end
            ST_W_ADD: begin
                cmd.tot_add = 1'b1;
                if (!wsel_reg) begin
                    cmd.w_clr  = 1'b1;
                    wsel_next  = 1'b1;
                    chunk_next = 2'd3;
                    state_next = ST_W_MUL;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            chunk_reg <= 2'd0;
            wsel_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
            wsel_reg  <= wsel_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    `PLC_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, state_reg == ST_MUL_V)
    `PLC_ASSERT_SAME(a_load_when_free, aclk, aresetn, cmd.out_ld, status.out_free)
    `PLC_ASSERT_NEXT(a_div_not_instant, aclk, aresetn, cmd.div_start, !status.div_done)
    `PLC_ASSERT_SAME(a_last_chunk, aclk, aresetn, state_reg == ST_W_ADD, chunk_reg == 2'd0)

endmodule

// ===== rtl/core/physics_loss_accumulator.sv =====
// Physics loss accumulator.
// The input channel (s_valid, s_ready, s_data) takes one subcell prediction per
// transaction together with the coarse values and model coefficients of its hex.
// The result channel (m_valid, m_ready, m_data) gives one transaction per batch,
// after the subcell marked batch_end: the three loss sums, their weighted total
// and the overflow flag. The user must write the loss weights on the cfg_ port
// only while idle; the block itself does not enforce this. A subcell that does
// not close a hex is worked in turn on the single shared multiplier, which forms
// the three model products and the square. A subcell that closes a hex also runs
// the serial divider, which produces the two hex means one quotient bit per
// cycle, 24 bits each. At the batch end the weighted total is formed from four
// 16-bit partial products per weight on the same multiplier.
// A result sits in an output register; the next subcell is accepted while it
// waits, and the block only holds at the following batch end if the receiver
// is still stalling. Reset clears the hex sums and the loss accumulators,
// sets both weights to 1.0 and leaves no result pending.
module physics_loss_accumulator #(
    parameter int CELLS_MAX = plc_pkg::CELLS_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  plc_pkg::plc_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output plc_pkg::plc_out_t                 m_data,
    input  logic                              cfg_wr_en,
    input  logic [plc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [plc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Command and status between the sequencer and the datapath.
    plc_pkg::plc_cmd_t    cmd;
    plc_pkg::plc_status_t status;

    plc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    plc_dp #(
        .CELLS_MAX(CELLS_MAX)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
